@@ design/osknav_pkg.sv @@
// ----------------------------------------------------------------------------
// osknav_pkg
// Shared types, key and emit codes, and the character tables of the
// on-screen keyboard navigator.
// ----------------------------------------------------------------------------
package osknav_pkg;

  localparam int unsigned KbCols = 10;
  localparam int unsigned KbRows = 4;
  localparam int unsigned KbSpecial = 4;

  // key codes
  localparam logic [3:0] KEY_UP    = 4'd0;
  localparam logic [3:0] KEY_DOWN  = 4'd1;
  localparam logic [3:0] KEY_LEFT  = 4'd2;
  localparam logic [3:0] KEY_RIGHT = 4'd3;
  localparam logic [3:0] KEY_A     = 4'd4;
  localparam logic [3:0] KEY_B     = 4'd5;
  localparam logic [3:0] KEY_ESC   = 4'd6;
  localparam logic [3:0] KEY_ENTER = 4'd7;

  // emitted action codes
  localparam logic [1:0] EMIT_NONE  = 2'd0;
  localparam logic [1:0] EMIT_CHAR  = 2'd1;
  localparam logic [1:0] EMIT_BKSP  = 2'd2;
  localparam logic [1:0] EMIT_ENTER = 2'd3;

  // special row and its keys
  localparam logic [2:0] ROW_SPECIAL = 3'(KbRows);
  localparam logic [3:0] COL_SHIFT   = 4'd0;
  localparam logic [3:0] COL_SPACE   = 4'd1;
  localparam logic [3:0] COL_BKSP    = 4'd2;
  localparam logic [6:0] CHAR_SPACE  = 7'd32;

  localparam logic [0:KbRows-1][0:KbCols-1][7:0] LOWER_TAB = {
    "1234567890", "qwertyuiop", "asdfghjkl.", "zxcvbnm:/-"
  };
  localparam logic [0:KbRows-1][0:KbCols-1][7:0] UPPER_TAB = {
    "!@#$%^&*()", "QWERTYUIOP", "ASDFGHJKL,", "ZXCVBNM;?_"
  };

  typedef struct packed {
    logic [3:0] key_code;
    logic       pressed;
    logic       text_field_focused;
    logic       hardware_keyboard;
  } osknav_event_t;

  typedef struct packed {
    logic       is_open;
    logic       pass_next;
    logic [2:0] row_sel;
    logic [3:0] col_sel;
    logic       shift_on;
  } osknav_state_t;

  typedef struct packed {
    logic       consumed;
    logic [1:0] emit_kind;
    logic [6:0] emit_char;
    logic       shown;
    logic [2:0] cursor_row;
    logic [3:0] cursor_col;
    logic       shifted;
  } osknav_result_t;

  function automatic logic [3:0] row_width(input logic [2:0] row);
    return (row < ROW_SPECIAL) ? 4'(KbCols) : 4'(KbSpecial);
  endfunction

  // row must be a character row, col already limited to the last column
  function automatic logic [6:0] char_of(input logic [1:0] row, input logic [3:0] col,
                                         input logic shift);
    logic [7:0] c;
    c = shift ? UPPER_TAB[row][col] : LOWER_TAB[row][col];
    return c[6:0];
  endfunction

endpackage

@@ design/osknav_core.sv @@
// ----------------------------------------------------------------------------
// osknav_core
// Next-state and result logic for one key event against the current state.
// ----------------------------------------------------------------------------
module osknav_core
  import osknav_pkg::*;
(
  input  logic           enable,
  input  osknav_event_t  ev,
  input  osknav_state_t  st,
  output osknav_state_t  st_nxt,
  output osknav_result_t res
);

  logic       consumed;
  logic [1:0] kind;
  logic [6:0] ch;
  logic       gate_open;

  assign gate_open = enable && !ev.hardware_keyboard && ev.text_field_focused;

  always_comb begin
    logic [3:0] w;
    logic [3:0] c;
    logic [4:0] col_inc;
    st_nxt   = st;
    consumed = 1'b0;
    kind     = EMIT_NONE;
    ch       = '0;
    w        = row_width(st.row_sel);
    c        = (st.col_sel < 4'(KbCols)) ? st.col_sel : 4'(KbCols - 1);
    col_inc  = {1'b0, st.col_sel} + 5'd1;
    priority if (!gate_open) begin
      st_nxt.is_open = 1'b0;
    end else if (!st.is_open) begin
      if (ev.pressed && ev.key_code == KEY_A) begin
        st_nxt.is_open  = 1'b1;
        st_nxt.row_sel  = '0;
        st_nxt.col_sel  = '0;
        st_nxt.shift_on = 1'b0;
        consumed        = 1'b1;
      end
    end else if (st.pass_next) begin
      st_nxt.pass_next = 1'b0;
    end else if (ev.key_code == KEY_B || ev.key_code == KEY_ESC) begin
      if (ev.pressed) begin
        st_nxt.is_open = 1'b0;
      end
      consumed = 1'b1;
    end else if (!ev.pressed) begin
      consumed = (ev.key_code <= KEY_A) || (ev.key_code == KEY_ENTER);
    end else if (ev.key_code <= KEY_ENTER) begin
      consumed = 1'b1;
      unique case (ev.key_code)
        KEY_UP: begin
          st_nxt.row_sel = (st.row_sel == '0) ? ROW_SPECIAL : st.row_sel - 3'd1;
        end
        KEY_DOWN: begin
          st_nxt.row_sel = (st.row_sel >= ROW_SPECIAL) ? 3'd0 : st.row_sel + 3'd1;
        end
        KEY_LEFT: begin
          st_nxt.col_sel = (st.col_sel == '0) ? w - 4'd1 : st.col_sel - 4'd1;
        end
        KEY_RIGHT: begin
          st_nxt.col_sel = (col_inc >= {1'b0, w}) ? 4'd0 : col_inc[3:0];
        end
        default: begin
          // A or Enter selects the key under the cursor
          priority if (st.row_sel < ROW_SPECIAL) begin
            kind = EMIT_CHAR;
            ch   = char_of(st.row_sel[1:0], c, st.shift_on);
          end else if (st.col_sel == COL_SHIFT) begin
            st_nxt.shift_on = !st.shift_on;
          end else if (st.col_sel == COL_SPACE) begin
            kind = EMIT_CHAR;
            ch   = CHAR_SPACE;
          end else if (st.col_sel == COL_BKSP) begin
            kind = EMIT_BKSP;
          end else begin
            kind             = EMIT_ENTER;
            st_nxt.pass_next = 1'b1;
            st_nxt.is_open   = 1'b0;
          end
        end
      endcase
      // clamp to the width of the row now selected
      w = row_width(st_nxt.row_sel);
      if (st_nxt.col_sel >= w) begin
        st_nxt.col_sel = w - 4'd1;
      end
    end
  end

  always_comb begin
    res.consumed   = consumed;
    res.emit_kind  = kind;
    res.emit_char  = ch;
    res.shown      = st_nxt.is_open && gate_open;
    res.cursor_row = st_nxt.row_sel;
    res.cursor_col = st_nxt.col_sel;
    res.shifted    = st_nxt.shift_on;
  end

endmodule

@@ design/onscreen_keyboard_navigator_unit.sv @@
// ----------------------------------------------------------------------------
// onscreen_keyboard_navigator_unit
// Controller-driven on-screen keyboard: cursor, shift and open state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one key event per transfer. Result channel (out_*):
//   exactly one result per event, in order: consumed flag, emitted action,
//   visible state and cursor after the event.
//   cfg_we/cfg_wdata write the enable bit; write it only while no event is
//   in flight.
//   An event is taken into the input register; the result register loads
//   the core's result when the event fires, and the result is offered
//   from there. Throughput: one event per cycle while the receiver does not
//   stall; the state update is a single short combinational step between
//   the registers. When the receiver stalls, the result register holds; if
//   the input register is still free, one more event is taken; after that
//   in_stall follows out_stall until the result is moved on.
//   Reset (rst_n low, synchronous) closes the keyboard, clears the cursor,
//   shift and pass-next state, sets enable to 1 and empties both registers.
// ----------------------------------------------------------------------------
module onscreen_keyboard_navigator_unit
  import osknav_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_key_code,
  input  logic       in_pressed,
  input  logic       in_text_field_focused,
  input  logic       in_hardware_keyboard,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_consumed,
  output logic [1:0] out_emit_kind,
  output logic [6:0] out_emit_char,
  output logic       out_shown,
  output logic [2:0] out_cursor_row,
  output logic [3:0] out_cursor_col,
  output logic       out_shifted
);

  logic           enable_r;
  logic           ev_v_r;
  osknav_event_t  ev_r;
  logic           out_v_r;
  osknav_result_t res_r;
  osknav_state_t  st_r;
  osknav_state_t  st_nxt;
  osknav_result_t res_nxt;
  logic           in_xfer;
  logic           fire;

  osknav_core u_core (
    .enable (enable_r),
    .ev     (ev_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign fire     = ev_v_r && (!out_v_r || !out_stall);
  assign in_stall = ev_v_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      ev_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      st_r     <= '0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      if (in_xfer) begin
        ev_v_r <= 1'b1;
      end else if (fire) begin
        ev_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r.key_code           <= in_key_code;
      ev_r.pressed            <= in_pressed;
      ev_r.text_field_focused <= in_text_field_focused;
      ev_r.hardware_keyboard  <= in_hardware_keyboard;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_consumed   = res_r.consumed;
  assign out_emit_kind  = res_r.emit_kind;
  assign out_emit_char  = res_r.emit_char;
  assign out_shown      = res_r.shown;
  assign out_cursor_row = res_r.cursor_row;
  assign out_cursor_col = res_r.cursor_col;
  assign out_shifted    = res_r.shifted;

endmodule

@@ design/osknav_checker.sv @@
// ----------------------------------------------------------------------------
// osknav_checker
// Port-level checks on the navigator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module osknav_checker
  import osknav_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_consumed,
  input logic [1:0] out_emit_kind,
  input logic [6:0] out_emit_char,
  input logic [2:0] out_cursor_row,
  input logic [3:0] out_cursor_col
);

  // a held result must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_kind != EMIT_CHAR |-> out_emit_char == '0)
    else $error("character code without a character emitted");

  // anything typed means the event was swallowed, and only while open
  a_emit_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_kind != EMIT_NONE |-> out_consumed)
    else $error("emission on an event passed through");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_row < ROW_SPECIAL && out_cursor_col < 4'(KbCols)) ||
                  (out_cursor_row == ROW_SPECIAL && out_cursor_col < 4'(KbSpecial)))
    else $error("cursor outside the keyboard");

endmodule

bind onscreen_keyboard_navigator_unit osknav_checker u_osknav_checker (.*);

@@ sim/onscreen_keyboard_navigator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// onscreen_keyboard_navigator_unit_tb
// Self-checking bench for the on-screen keyboard navigator. Key events are
// queued by phase and sent by a clocked driver. Each accepted transfer is run
// through a local keyboard predictor. A clocked monitor checks every result,
// field by field, against the oldest prediction. Both channels idle at
// random. The enable bit is toggled between phases while the block is idle.
// ----------------------------------------------------------------------------
module onscreen_keyboard_navigator_unit_tb
  import osknav_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 13;
  localparam logic [3:0] KEY_OTHER = 4'd8;
  localparam logic [3:0] KEY_TOP = 4'd15;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_key_code;
  logic       in_pressed;
  logic       in_text_field_focused;
  logic       in_hardware_keyboard;
  logic       out_valid;
  logic       out_stall;
  logic       out_consumed;
  logic [1:0] out_emit_kind;
  logic [6:0] out_emit_char;
  logic       out_shown;
  logic [2:0] out_cursor_row;
  logic [3:0] out_cursor_col;
  logic       out_shifted;

  onscreen_keyboard_navigator_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_key_code           (in_key_code),
    .in_pressed            (in_pressed),
    .in_text_field_focused (in_text_field_focused),
    .in_hardware_keyboard  (in_hardware_keyboard),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_consumed          (out_consumed),
    .out_emit_kind         (out_emit_kind),
    .out_emit_char         (out_emit_char),
    .out_shown             (out_shown),
    .out_cursor_row        (out_cursor_row),
    .out_cursor_col        (out_cursor_col),
    .out_shifted           (out_shifted)
  );

  osknav_event_t  key_events_to_send[$];
  osknav_result_t outcomes_due[$];
  int unsigned    cycle_count = 0;
  int unsigned    fail_count = 0;
  logic           quiet_stretch;

  // predictor copy of the keyboard
  logic       kb_enable = 1'b1;
  logic       kb_open = 1'b0;
  logic       kb_pass = 1'b0;
  logic [2:0] kb_row = '0;
  logic [3:0] kb_col = '0;
  logic       kb_shift = 1'b0;

  string plain_rows[4] = '{"1234567890", "qwertyuiop", "asdfghjkl.", "zxcvbnm:/-"};
  string shift_rows[4] = '{"!@#$%^&*()", "QWERTYUIOP", "ASDFGHJKL,", "ZXCVBNM;?_"};

  // recurring long window, set by cycle_count, with no idling on either side
  assign quiet_stretch = (cycle_count % 1600) >= 600 && (cycle_count % 1600) < 1000;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic osknav_result_t predict_key_event(osknav_event_t ev);
    osknav_result_t r;
    logic [3:0]     key;
    int             width;
    int             c;
    r = '0;
    key = (ev.key_code > KEY_OTHER) ? KEY_OTHER : ev.key_code;
    if (!kb_enable || ev.hardware_keyboard || !ev.text_field_focused) begin
      kb_open = 1'b0;
    end else if (!kb_open) begin
      if (ev.pressed && key == KEY_A) begin
        kb_open = 1'b1;
        kb_row = '0;
        kb_col = '0;
        kb_shift = 1'b0;
        r.consumed = 1'b1;
      end
    end else if (kb_pass) begin
      kb_pass = 1'b0;
    end else if (key == KEY_B || key == KEY_ESC) begin
      if (ev.pressed) kb_open = 1'b0;
      r.consumed = 1'b1;
    end else if (!ev.pressed) begin
      r.consumed = (key <= KEY_A || key == KEY_ENTER);
    end else if (key != KEY_OTHER) begin
      r.consumed = 1'b1;
      width = (kb_row < ROW_SPECIAL) ? KbCols : KbSpecial;
      case (key)
        KEY_UP:    kb_row = (kb_row == 0) ? ROW_SPECIAL : kb_row - 3'd1;
        KEY_DOWN:  kb_row = (kb_row >= ROW_SPECIAL) ? 3'd0 : kb_row + 3'd1;
        KEY_LEFT:  kb_col = (kb_col == 0) ? 4'(width - 1) : kb_col - 4'd1;
        KEY_RIGHT: kb_col = (int'(kb_col) + 1 >= width) ? 4'd0 : kb_col + 4'd1;
        default: begin
          if (kb_row < ROW_SPECIAL) begin
            c = (kb_col < KbCols) ? int'(kb_col) : KbCols - 1;
            r.emit_kind = EMIT_CHAR;
            r.emit_char = kb_shift ? 7'(shift_rows[kb_row][c]) : 7'(plain_rows[kb_row][c]);
          end else if (kb_col == COL_SHIFT) begin
            kb_shift = !kb_shift;
          end else if (kb_col == COL_SPACE) begin
            r.emit_kind = EMIT_CHAR;
            r.emit_char = CHAR_SPACE;
          end else if (kb_col == COL_BKSP) begin
            r.emit_kind = EMIT_BKSP;
          end else begin
            // enter key: hand the next event through and close
            r.emit_kind = EMIT_ENTER;
            kb_pass = 1'b1;
            kb_open = 1'b0;
          end
        end
      endcase
      width = (kb_row < ROW_SPECIAL) ? KbCols : KbSpecial;
      if (kb_col >= width) kb_col = 4'(width - 1);
    end
    r.shown = kb_open && kb_enable && ev.text_field_focused && !ev.hardware_keyboard;
    r.cursor_row = kb_row;
    r.cursor_col = kb_col;
    r.shifted = kb_shift;
    return r;
  endfunction

  // driver: a stalled transfer holds; otherwise load the next event or idle
  always @(posedge clk) begin : drive_events
    osknav_event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_key_code <= '0;
      in_pressed <= 1'b0;
      in_text_field_focused <= 1'b0;
      in_hardware_keyboard <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ev = {in_key_code, in_pressed, in_text_field_focused, in_hardware_keyboard};
        outcomes_due.push_back(predict_key_event(ev));
      end
      if (!(in_valid && in_stall)) begin
        if (key_events_to_send.size() != 0 &&
            (quiet_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
          ev = key_events_to_send.pop_front();
          in_valid <= 1'b1;
          in_key_code <= ev.key_code;
          in_pressed <= ev.pressed;
          in_text_field_focused <= ev.text_field_focused;
          in_hardware_keyboard <= ev.hardware_keyboard;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_outcome();
    osknav_result_t want;
    if (outcomes_due.size() == 0) begin
      fail_count++;
      $display("%0t: result with no event outstanding, expected none, got consumed=%0d",
               $time, out_consumed);
    end else begin
      want = outcomes_due.pop_front();
      compare_field("consumed", int'(want.consumed), int'(out_consumed));
      compare_field("emit_kind", int'(want.emit_kind), int'(out_emit_kind));
      compare_field("emit_char", int'(want.emit_char), int'(out_emit_char));
      compare_field("shown", int'(want.shown), int'(out_shown));
      compare_field("cursor_row", int'(want.cursor_row), int'(out_cursor_row));
      compare_field("cursor_col", int'(want.cursor_col), int'(out_cursor_col));
      compare_field("shifted", int'(want.shifted), int'(out_shifted));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_outcome();
      out_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic queue_event(logic [3:0] key, logic pressed, logic focus, logic hw);
    osknav_event_t ev;
    ev.key_code = key;
    ev.pressed = pressed;
    ev.text_field_focused = focus;
    ev.hardware_keyboard = hw;
    key_events_to_send.push_back(ev);
  endtask

  // mostly focused presses that drive the keyboard about; the rest is noise
  task automatic queue_random_events(int count);
    int roll;
    logic [3:0] key;
    repeat (count) begin
      if ($urandom_range(99) < 85) begin
        roll = $urandom_range(99);
        if (roll < 55)      key = 4'($urandom_range(3));
        else if (roll < 75) key = KEY_A;
        else if (roll < 87) key = KEY_ENTER;
        else if (roll < 92) key = KEY_B;
        else if (roll < 95) key = KEY_ESC;
        else                key = 4'($urandom_range(KEY_TOP, KEY_OTHER));
        queue_event(key, $urandom_range(99) < 88, 1'b1, 1'b0);
      end else begin
        queue_event(4'($urandom_range(KEY_TOP)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    while (key_events_to_send.size() != 0 || in_valid || outcomes_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    kb_enable = value;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk with the keyboard enabled from reset
    queue_event(KEY_UP, 1'b1, 1'b1, 1'b0);     // closed: passes on
    queue_event(KEY_A, 1'b0, 1'b1, 1'b0);      // release while closed
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // open
    queue_event(KEY_LEFT, 1'b1, 1'b1, 1'b0);   // wrap to column 9
    queue_event(KEY_ENTER, 1'b1, 1'b1, 1'b0);  // type lower char
    queue_event(KEY_UP, 1'b1, 1'b1, 1'b0);     // wrap to special row, column clamped
    queue_event(KEY_RIGHT, 1'b1, 1'b1, 1'b0);  // wrap to shift key
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // shift on
    queue_event(KEY_DOWN, 1'b1, 1'b1, 1'b0);   // wrap to row 0
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // type upper char
    queue_event(KEY_RIGHT, 1'b0, 1'b1, 1'b0);  // arrow release swallowed
    queue_event(KEY_OTHER, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_TOP, 1'b1, 1'b1, 1'b0);    // out-of-range code acts as other
    queue_event(4'd9, 1'b0, 1'b1, 1'b0);
    queue_event(KEY_UP, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_RIGHT, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_ENTER, 1'b1, 1'b1, 1'b0);  // space
    queue_event(KEY_RIGHT, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // backspace tap
    queue_event(KEY_RIGHT, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // enter tap, closes, pass-next set
    queue_event(KEY_ESC, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);      // reopen
    queue_event(KEY_B, 1'b0, 1'b1, 1'b0);      // passed through, pass-next cleared
    queue_event(KEY_B, 1'b0, 1'b1, 1'b0);      // close key release swallowed
    queue_event(KEY_ESC, 1'b1, 1'b1, 1'b0);    // close
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_DOWN, 1'b1, 1'b1, 1'b1);   // hardware keyboard closes
    queue_event(KEY_A, 1'b1, 1'b1, 1'b1);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);
    queue_event(KEY_DOWN, 1'b1, 1'b0, 1'b0);   // focus lost closes
    wait_until_drained();

    write_enable(1'b0);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);
    queue_random_events(30);
    wait_until_drained();

    write_enable(1'b1);
    queue_random_events(620);
    wait_until_drained();

    write_enable(1'b0);
    queue_random_events(20);
    wait_until_drained();

    write_enable(1'b1);
    queue_event(KEY_A, 1'b1, 1'b1, 1'b0);
    queue_random_events(60);
    wait_until_drained();

    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/osknav_pkg.sv
design/osknav_core.sv
design/onscreen_keyboard_navigator_unit.sv
design/osknav_checker.sv
sim/onscreen_keyboard_navigator_unit_tb.sv
